/* rtl/core/idv_pkg.sv */
// shared types and constants for the pipelined integer divider
// no dependencies; imported by every divider module
package idv_pkg;

	// width of the operand and result ports
	localparam int IDV_FIELD_W = 32;

	// default internal arithmetic width
	localparam int IDV_DATA_WIDTH = 32;

	// control that travels with each item down the pipeline
	typedef struct packed {
		logic vld;
		logic neg_q;
		logic neg_r;
	} ctl_t;

endpackage

/* rtl/core/idv_prep.sv */
// input stage: takes the transfer, forms operand magnitudes and sign flags
// depends on idv_pkg
module idv_prep import idv_pkg::*; #(
	parameter int DATA_WIDTH = IDV_DATA_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   operation,
	input  logic [IDV_FIELD_W-1:0] dividend,
	input  logic [IDV_FIELD_W-1:0] divisor,
	input  logic                   ready_i,
	output logic                   ready_o,
	output ctl_t                   ctl_o,
	output logic [DATA_WIDTH-1:0]  rem_o,
	output logic [DATA_WIDTH-1:0]  quo_o,
	output logic [DATA_WIDTH-1:0]  dsr_o
);

	logic [DATA_WIDTH-1:0] a, b, ua, ub;
	logic                  neg_a, neg_b;
	ctl_t                  ctl_s;
	logic [DATA_WIDTH-1:0] quo_s, dsr_s;

	always_comb begin
		a     = DATA_WIDTH'(dividend);
		b     = DATA_WIDTH'(divisor);
		neg_a = operation & a[DATA_WIDTH-1];
		neg_b = operation & b[DATA_WIDTH-1];
		ua    = neg_a ? (~a + DATA_WIDTH'(1)) : a;
		ub    = neg_b ? (~b + DATA_WIDTH'(1)) : b;
	end

	assign ready_o = !ctl_s.vld || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else if (ready_o) begin
			ctl_s.vld   <= in_valid;
			ctl_s.neg_q <= neg_a ^ neg_b;
			ctl_s.neg_r <= neg_a;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && in_valid) begin
			quo_s <= ua;
			dsr_s <= ub;
		end
	end

	assign ctl_o = ctl_s;
	// partial remainder starts at zero
	assign rem_o = '0;
	assign quo_o = quo_s;
	assign dsr_o = dsr_s;

endmodule

/* rtl/core/idv_step.sv */
// one restoring shift-subtract step: retires one quotient bit per stage
// depends on idv_pkg
module idv_step import idv_pkg::*; #(
	parameter int DATA_WIDTH = IDV_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_t                  ctl_i,
	input  logic [DATA_WIDTH-1:0] rem_i,
	input  logic [DATA_WIDTH-1:0] quo_i,
	input  logic [DATA_WIDTH-1:0] dsr_i,
	input  logic                  ready_i,
	output logic                  ready_o,
	output ctl_t                  ctl_o,
	output logic [DATA_WIDTH-1:0] rem_o,
	output logic [DATA_WIDTH-1:0] quo_o,
	output logic [DATA_WIDTH-1:0] dsr_o
);

	logic [DATA_WIDTH-1:0] sh;
	logic [DATA_WIDTH+1:0] diff;
	logic                  take;
	ctl_t                  ctl_s;
	logic [DATA_WIDTH-1:0] rem_s, quo_s, dsr_s;

	// quo carries the remaining dividend bits on top, quotient bits enter at the bottom
	always_comb begin
		sh   = {rem_i[DATA_WIDTH-2:0], quo_i[DATA_WIDTH-1]};
		diff = {1'b0, rem_i[DATA_WIDTH-1], sh} - {2'b00, dsr_i};
		take = !diff[DATA_WIDTH+1];
	end

	assign ready_o = !ctl_s.vld || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else if (ready_o) begin
			ctl_s <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && ctl_i.vld) begin
			rem_s <= take ? diff[DATA_WIDTH-1:0] : sh;
			quo_s <= {quo_i[DATA_WIDTH-2:0], take};
			dsr_s <= dsr_i;
		end
	end

	assign ctl_o = ctl_s;
	assign rem_o = rem_s;
	assign quo_o = quo_s;
	assign dsr_o = dsr_s;

endmodule

/* rtl/core/idv_post.sv */
// output stage: applies result signs and holds the result for transfer
// depends on idv_pkg
module idv_post import idv_pkg::*; #(
	parameter int DATA_WIDTH = IDV_DATA_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_t                   ctl_i,
	input  logic [DATA_WIDTH-1:0]  rem_i,
	input  logic [DATA_WIDTH-1:0]  quo_i,
	output logic                   ready_o,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [IDV_FIELD_W-1:0] quotient,
	output logic [IDV_FIELD_W-1:0] remainder
);

	logic                  vld_s;
	logic [DATA_WIDTH-1:0] quo_s, rem_s;

	assign ready_o = !vld_s || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (ready_o) begin
			vld_s <= ctl_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && ctl_i.vld) begin
			quo_s <= ctl_i.neg_q ? (~quo_i + DATA_WIDTH'(1)) : quo_i;
			rem_s <= ctl_i.neg_r ? (~rem_i + DATA_WIDTH'(1)) : rem_i;
		end
	end

	assign out_valid = vld_s;
	assign quotient  = IDV_FIELD_W'(quo_s);
	assign remainder = IDV_FIELD_W'(rem_s);

endmodule

/* rtl/core/int_divider_signed_unsigned.sv */
// Pipelined restoring integer divider, signed or unsigned. Each transfer on the
// input carries a mode flag, a dividend and a divisor; one transfer on the output
// returns quotient and remainder. A new item can enter every cycle unless the
// pipeline has backed up to the input: there is one shift-subtract stage per
// quotient bit (DATA_WIDTH stages), plus an input stage that takes operand
// magnitudes and an output stage that restores signs. Stalls ripple backward only
// as far as the first empty stage, so bubbles are squeezed out and the input keeps
// taking items while a finished result waits at the output. Signed mode truncates
// the quotient toward zero and gives the remainder the dividend's sign. A zero
// divisor yields an all-ones quotient (signed: -1, or +1 for a negative dividend)
// with the dividend as remainder; most-negative divided by -1 wraps to itself with
// remainder zero. Operand bits above DATA_WIDTH are ignored.
// depends on idv_pkg, idv_prep, idv_step, idv_post
module int_divider_signed_unsigned import idv_pkg::*; #(
	parameter int DATA_WIDTH = IDV_DATA_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [IDV_FIELD_W-1:0] dividend,
	input  logic [IDV_FIELD_W-1:0] divisor,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [IDV_FIELD_W-1:0] quotient,
	output logic [IDV_FIELD_W-1:0] remainder
);

	localparam int NSTG = DATA_WIDTH + 2;

	// index k is the output of stage k: 0 is the input stage, 1..DATA_WIDTH the steps
	ctl_t                  ctl_w [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_w [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] quo_w [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] dsr_w [0:DATA_WIDTH];
	// rdy_w[k] is the ready of the stage that consumes index k
	logic                  rdy_w [0:DATA_WIDTH];
	logic                  prep_rdy;
	logic [NSTG-1:0]       vld_vec;

	// input stage: magnitudes and sign flags
	idv_prep #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.operation(operation),
		.dividend (dividend),
		.divisor  (divisor),
		.ready_i  (rdy_w[0]),
		.ready_o  (prep_rdy),
		.ctl_o    (ctl_w[0]),
		.rem_o    (rem_w[0]),
		.quo_o    (quo_w[0]),
		.dsr_o    (dsr_w[0])
	);

	assign in_stall = !prep_rdy;

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
		idv_step #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_w[k]),
			.rem_i  (rem_w[k]),
			.quo_i  (quo_w[k]),
			.dsr_i  (dsr_w[k]),
			.ready_i(rdy_w[k+1]),
			.ready_o(rdy_w[k]),
			.ctl_o  (ctl_w[k+1]),
			.rem_o  (rem_w[k+1]),
			.quo_o  (quo_w[k+1]),
			.dsr_o  (dsr_w[k+1])
		);
		assign vld_vec[k+1] = ctl_w[k+1].vld;
	end

	assign vld_vec[0] = ctl_w[0].vld;

	// sign fix-up and output register
	idv_post #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_i    (ctl_w[DATA_WIDTH]),
		.rem_i    (rem_w[DATA_WIDTH]),
		.quo_i    (quo_w[DATA_WIDTH]),
		.ready_o  (rdy_w[DATA_WIDTH]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quotient (quotient),
		.remainder(remainder)
	);

	assign vld_vec[NSTG-1] = out_valid;

`ifndef SYNTHESIS
	// the input only stalls when the first stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> ctl_w[0].vld)
		else $error("input stalled with empty first stage");

	// items in flight are conserved when nothing enters or leaves
	a_hold_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && !in_stall) && !(out_valid && !out_stall)) |=>
		$countones(vld_vec) == $past($countones(vld_vec)))
		else $error("pipeline item count changed without a transfer");

	// an accepted item with no delivery grows the count by one
	a_add_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		((in_valid && !in_stall) && !(out_valid && !out_stall)) |=>
		$countones(vld_vec) == $past($countones(vld_vec)) + 1)
		else $error("accepted item lost or duplicated");

	// a delivery with no new item shrinks the count by one
	a_sub_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && !in_stall) && (out_valid && !out_stall)) |=>
		$countones(vld_vec) + 1 == $past($countones(vld_vec)))
		else $error("delivered item not retired");
`endif

endmodule

/* test/int_divider_signed_unsigned_tb.sv */
// self-checking testbench for the pipelined signed/unsigned integer divider
// predicts quotient and remainder by restoring division and checks every output transfer
// depends on idv_pkg and int_divider_signed_unsigned
module int_divider_signed_unsigned_tb import idv_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// division modes as carried on the operation input
	localparam logic OP_UNSIGNED = 1'b0;
	localparam logic OP_SIGNED   = 1'b1;

	// one prep stage, one stage per quotient bit, one sign stage
	localparam int PIPE_LATENCY = IDV_DATA_WIDTH + 2;
	// cycles with no transfer on either side before the run is abandoned
	localparam int STALL_LIMIT  = 5000;
	// length of the long receiver hold-off
	localparam int HOLDOFF_LEN  = 300;

	typedef enum int {
		RX_READY,
		RX_RANDOM,
		RX_BURSTY
	} rx_mode_t;

	// one division in flight: operands and the quotient and remainder it must give
	typedef struct {
		logic                   op;
		logic [IDV_FIELD_W-1:0] num;
		logic [IDV_FIELD_W-1:0] den;
		logic [IDV_FIELD_W-1:0] quo;
		logic [IDV_FIELD_W-1:0] rem;
	} division_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic                   operation = OP_UNSIGNED;
	logic [IDV_FIELD_W-1:0] dividend  = '0;
	logic [IDV_FIELD_W-1:0] divisor   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [IDV_FIELD_W-1:0] quotient;
	logic [IDV_FIELD_W-1:0] remainder;

	// divisions accepted by the block whose results have not come out yet
	division_t pending_divisions[$];

	int error_count     = 0;
	int sent_count      = 0;
	int signed_count    = 0;
	int zero_div_count  = 0;
	int result_count    = 0;
	int idle_cycles     = 0;

	// sender pacing: bursts of random length separated by random gaps
	bit gaps_on    = 1'b0;
	int burst_left = 0;

	// receiver pacing
	rx_mode_t rx_mode      = RX_READY;
	int       holdoff_req  = 0;
	int       holdoff_left = 0;
	bit       rx_stalling  = 1'b0;
	int       rx_run_left  = 0;

	int_divider_signed_unsigned uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.dividend  (dividend),
		.divisor   (divisor),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.quotient  (quotient),
		.remainder (remainder)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// quotient and remainder prediction
	// ------------------------------------------------------------------

	// shift-subtract restoring division, {quotient, remainder}
	// a carry out of the partial remainder always forces a subtract, so a
	// zero divisor gives an all-ones quotient and the dividend back
	function automatic logic [2*IDV_FIELD_W-1:0] restore_divide(
		input logic [IDV_FIELD_W-1:0] n,
		input logic [IDV_FIELD_W-1:0] d
	);
		logic [IDV_FIELD_W-1:0] q;
		logic [IDV_FIELD_W-1:0] r;
		logic                   carry;
		q = '0;
		r = '0;
		for (int i = IDV_FIELD_W - 1; i >= 0; i--) begin
			carry = r[IDV_FIELD_W-1];
			r = {r[IDV_FIELD_W-2:0], n[i]};
			if (carry || r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return {q, r};
	endfunction

	function automatic division_t predict_division(
		input logic                   op,
		input logic [IDV_FIELD_W-1:0] a,
		input logic [IDV_FIELD_W-1:0] b
	);
		division_t              e;
		logic                   neg_a;
		logic                   neg_b;
		logic [IDV_FIELD_W-1:0] mag_a;
		logic [IDV_FIELD_W-1:0] mag_b;
		logic [IDV_FIELD_W-1:0] mag_q;
		logic [IDV_FIELD_W-1:0] mag_r;
		e.op  = op;
		e.num = a;
		e.den = b;
		if (op == OP_UNSIGNED) begin
			{e.quo, e.rem} = restore_divide(a, b);
		end else begin
			neg_a = a[IDV_FIELD_W-1];
			neg_b = b[IDV_FIELD_W-1];
			mag_a = neg_a ? -a : a;
			mag_b = neg_b ? -b : b;
			{mag_q, mag_r} = restore_divide(mag_a, mag_b);
			// truncate toward zero, remainder follows from the wrapped quotient
			e.quo = (neg_a ^ neg_b) ? -mag_q : mag_q;
			e.rem = a - e.quo * b;
		end
		return e;
	endfunction

	// operand shapes that reach the interesting corners of the datapath
	function automatic logic [IDV_FIELD_W-1:0] pick_operand();
		logic [IDV_FIELD_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 15);
			1: v = -$urandom_range(1, 15);
			2: begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = 32'h0000_0001;
					2: v = 32'h7FFF_FFFF;
					3: v = 32'h8000_0000;
					4: v = 32'hFFFF_FFFF;
					default: v = 32'h8000_0001;
				endcase
			end
			3, 4: v = $urandom() >> $urandom_range(1, 31);
			5: v = 32'h1 << $urandom_range(0, 31);
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------

	// offer one division and wait for the transfer; valid stays up between
	// items of a burst and only drops when a gap starts
	task automatic send_division(
		input logic                   op,
		input logic [IDV_FIELD_W-1:0] a,
		input logic [IDV_FIELD_W-1:0] b
	);
		int gap;
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 24);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		operation <= op;
		dividend  <= a;
		divisor   <= b;
		// in_stall is sampled before the edge updates settle
		do @(posedge clk); while (in_stall);
		pending_divisions.push_back(predict_division(op, a, b));
		sent_count++;
		if (op == OP_SIGNED)
			signed_count++;
		if (b == '0)
			zero_div_count++;
	endtask

	// drop valid and wait until every accepted division has produced its result
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_divisions.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(input int count, input int signed_pct);
		logic                   op;
		logic [IDV_FIELD_W-1:0] b;
		repeat (count) begin
			op = ($urandom_range(0, 99) < signed_pct) ? OP_SIGNED : OP_UNSIGNED;
			b  = ($urandom_range(0, 39) == 0) ? '0 : pick_operand();
			send_division(op, pick_operand(), b);
		end
	endtask

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------

	// receiver stall pattern, one assignment of out_stall per falling edge
	always @(negedge clk) begin
		if (holdoff_req != 0) begin
			holdoff_left = holdoff_req;
			holdoff_req  = 0;
		end
		if (holdoff_left > 0) begin
			// long hold-off so the pipeline fills and backs up to the input
			holdoff_left--;
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
				RX_READY: out_stall <= 1'b0;
				RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
				RX_BURSTY: begin
					if (rx_run_left == 0) begin
						rx_stalling = ~rx_stalling;
						rx_run_left = rx_stalling ? $urandom_range(1, 12)
						                          : $urandom_range(1, 20);
					end
					rx_run_left--;
					out_stall <= rx_stalling;
				end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// compare each output transfer with the oldest outstanding division
	always @(posedge clk) begin
		division_t e;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (pending_divisions.size() == 0) begin
				$display("%0t: unexpected result quotient=%h remainder=%h",
				         $time, quotient, remainder);
				error_count++;
			end else begin
				e = pending_divisions.pop_front();
				if (quotient !== e.quo) begin
					$display("%0t: quotient mismatch op=%b %h/%h expected %h actual %h",
					         $time, e.op, e.num, e.den, e.quo, quotient);
					error_count++;
				end
				if (remainder !== e.rem) begin
					$display("%0t: remainder mismatch op=%b %h/%h expected %h actual %h",
					         $time, e.op, e.num, e.den, e.rem, remainder);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
			         $time, STALL_LIMIT, pending_divisions.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// operand extremes, both modes and the special cases, back to back
	task automatic test_directed();
		gaps_on = 1'b0;
		rx_mode = RX_READY;
		send_division(OP_UNSIGNED, 32'h0000_0000, 32'h0000_0001);
		send_division(OP_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001);
		send_division(OP_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_division(OP_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0002);
		send_division(OP_UNSIGNED, 32'h0000_0064, 32'h0000_0007);
		send_division(OP_UNSIGNED, 32'h0000_0005, 32'h0000_0007);
		// zero divisor in unsigned mode
		send_division(OP_UNSIGNED, 32'h0000_0007, 32'h0000_0000);
		send_division(OP_UNSIGNED, 32'h0000_0000, 32'h0000_0000);
		send_division(OP_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0000);
		// most negative by minus one read as unsigned
		send_division(OP_UNSIGNED, 32'h8000_0000, 32'hFFFF_FFFF);
		// zero divisor in signed mode, both dividend signs
		send_division(OP_SIGNED,   32'h0000_0007, 32'h0000_0000);
		send_division(OP_SIGNED,   -32'd7,        32'h0000_0000);
		send_division(OP_SIGNED,   32'h0000_0000, 32'h0000_0000);
		send_division(OP_SIGNED,   32'h8000_0000, 32'h0000_0000);
		// most negative by minus one wraps
		send_division(OP_SIGNED,   32'h8000_0000, 32'hFFFF_FFFF);
		// sign combinations, truncation toward zero
		send_division(OP_SIGNED,   32'h0000_0007, -32'd2);
		send_division(OP_SIGNED,   -32'd7,        32'h0000_0002);
		send_division(OP_SIGNED,   -32'd7,        -32'd2);
		send_division(OP_SIGNED,   32'h0000_0064, 32'h0000_0007);
		send_division(OP_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000);
		send_division(OP_SIGNED,   32'h8000_0000, 32'h8000_0000);
		send_division(OP_SIGNED,   32'h8000_0000, 32'h0000_0001);
		send_division(OP_SIGNED,   32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_division(OP_SIGNED,   32'h1234_5678, 32'h0000_0001);
		wait_for_results();
	endtask

	// full rate with a receiver that never stalls
	task automatic test_streaming();
		gaps_on = 1'b0;
		rx_mode = RX_READY;
		send_random(400, 50);
	endtask

	// bursty sender against a randomly stalling receiver
	task automatic test_random_flow();
		gaps_on    = 1'b1;
		burst_left = 0;
		rx_mode    = RX_RANDOM;
		send_random(600, 50);
	endtask

	// receiver alternates runs of stall and ready
	task automatic test_bursty_receiver();
		gaps_on = 1'b1;
		rx_mode = RX_BURSTY;
		send_random(400, 60);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering,
	// so the pipeline fills and the input stalls
	task automatic test_output_holdoff();
		gaps_on     = 1'b0;
		rx_mode     = RX_READY;
		holdoff_req = HOLDOFF_LEN;
		send_random(150, 50);
		wait_for_results();
	endtask

	// short bursts, each followed by a pause until the pipeline is empty
	task automatic test_pause_and_drain();
		gaps_on = 1'b1;
		rx_mode = RX_RANDOM;
		repeat (5) begin
			send_random(50, 50);
			wait_for_results();
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_streaming();
		test_random_flow();
		test_bursty_receiver();
		test_output_holdoff();
		test_pause_and_drain();

		wait_for_results();
		// catch anything the block emits after the last expected result
		repeat (PIPE_LATENCY + 8) @(posedge clk);

		$display("covered %0d divisions (%0d signed, %0d by zero), %0d results checked",
		         sent_count, signed_count, zero_div_count, result_count);
		$display("with full-rate streaming, random stalls, a long output hold-off and drains");
		if (error_count == 0 && pending_divisions.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
